>>> src/cfi_pkg.sv
// cfi_pkg: types, constants and saturating Q16.16 arithmetic helpers
// shared by the cylindrical field interpolator and its testbench
package cfi_pkg;

    localparam int DATA_W      = 32;
    localparam int FRAC_BITS   = 16;
    localparam int INV_BITS    = 32;
    localparam int TABLE_WORDS = 26;
    localparam int WORD_COS    = 24;
    localparam int WORD_SIN    = 25;
    localparam int DIV_NUM_W   = 48;
    localparam int DIV_DEN_W   = 31;
    localparam int DIV_STEP    = 4;
    localparam int CFG_ADDR_W  = 3;
    localparam int S_TDATA_W   = 200;
    localparam int M_TDATA_W   = 384;
    localparam int IDX_W       = 5;

    // s_tdata field offsets
    localparam int OFS_INDEX = 0;
    localparam int OFS_VALUE = 5;
    localparam int OFS_X     = 37;
    localparam int OFS_Y     = 69;
    localparam int OFS_Z     = 101;
    localparam int OFS_R     = 133;
    localparam int OFS_PHI   = 164;

    typedef logic signed [DATA_W-1:0] q_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_Z_MIN,
        REG_R_MIN,
        REG_PHI_MIN,
        REG_INV_Z,
        REG_INV_R,
        REG_INV_PHI,
        REG_SCALE
    } cfg_reg_t;

    localparam q_t Q_ONE    = 32'sh0001_0000;
    localparam q_t Q_TWO_PI = 32'sh0006_487F;
    localparam q_t Q_MAX    = 32'sh7FFF_FFFF;
    localparam q_t Q_MIN    = 32'sh8000_0000;

    typedef struct packed {
        q_t [2:0] bc;
        q_t [2:0] dz;
        q_t [2:0] dr;
        q_t [2:0] dp;
    } itp_t;

    typedef struct packed {
        logic rz;
        logic negx;
        logic negy;
        q_t   ctab;
        q_t   stab;
    } side_t;

    function automatic q_t from_mag(input logic neg, input logic [65:0] m);
        if (m >= 66'h0_8000_0000) begin
            return neg ? Q_MIN : Q_MAX;
        end
        return neg ? -q_t'(m[DATA_W-1:0]) : q_t'(m[DATA_W-1:0]);
    endfunction

    function automatic q_t sadd(input q_t a, input q_t b);
        logic signed [DATA_W:0] s;
        s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
        if (s[DATA_W] != s[DATA_W-1]) begin
            return s[DATA_W] ? Q_MIN : Q_MAX;
        end
        return s[DATA_W-1:0];
    endfunction

    function automatic q_t ssub(input q_t a, input q_t b);
        logic signed [DATA_W:0] s;
        s = {a[DATA_W-1], a} - {b[DATA_W-1], b};
        if (s[DATA_W] != s[DATA_W-1]) begin
            return s[DATA_W] ? Q_MIN : Q_MAX;
        end
        return s[DATA_W-1:0];
    endfunction

    function automatic q_t addsub(input q_t a, input q_t b, input logic sub);
        return sub ? ssub(a, b) : sadd(a, b);
    endfunction

    // rounded magnitude product, shifted by FRAC_BITS or INV_BITS
    function automatic q_t mulsh(input logic signed [DATA_W:0] a,
                                 input logic signed [DATA_W:0] b, input logic inv);
        logic [DATA_W:0] ma;
        logic [DATA_W:0] mb;
        logic [65:0]     p;
        logic [65:0]     q;
        ma = a[DATA_W] ? (DATA_W+1)'(-a) : (DATA_W+1)'(a);
        mb = b[DATA_W] ? (DATA_W+1)'(-b) : (DATA_W+1)'(b);
        p  = 66'(ma) * 66'(mb);
        if (inv) begin
            q = (p + (66'd1 << (INV_BITS - 1))) >> INV_BITS;
        end else begin
            q = (p + (66'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        end
        return from_mag(a[DATA_W] ^ b[DATA_W], q);
    endfunction

    function automatic q_t mq(input q_t a, input q_t b);
        return mulsh({a[DATA_W-1], a}, {b[DATA_W-1], b}, 1'b0);
    endfunction

    function automatic q_t mi(input q_t a, input logic [DATA_W-1:0] inv);
        return mulsh({a[DATA_W-1], a}, {1'b0, inv}, 1'b1);
    endfunction

    function automatic q_t lerp(input q_t g, input q_t f, input q_t a, input q_t b);
        return sadd(mq(g, a), mq(f, b));
    endfunction

endpackage

>>> src/cylindrical_field_interpolator.sv
// cylindrical_field_interpolator: trilinear field interpolation in one cylindrical bin,
// rotation to Cartesian and all nine derivatives; uses cfi_pkg and cfi_div
//
// A beat with tuser set loads one of the 26 table words at once and gives no result; a
// query beat gives one result beat. One beat is taken every cycle while m_tready is
// high; the latency is set mostly by the 12-stage divider that forms x/r, y/r and 1/r,
// four quotient bits per stage. The table is read when the query is taken, so loads
// that follow a query do not affect it.
module cylindrical_field_interpolator (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // table_index, table_value, pos_x, pos_y, pos_z, radius, azimuth, zero pad
    input  logic [cfi_pkg::S_TDATA_W-1:0]   s_tdata,
    // action
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // b_x, b_y, b_z, dbx_dx, dbx_dy, dbx_dz, dby_dx, dby_dy, dby_dz, dbz_dx, dbz_dy, dbz_dz
    output logic [cfi_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                            cfg_wr_en,
    input  logic [cfi_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [cfi_pkg::DATA_W-1:0]      cfg_wdata
);

    import cfi_pkg::*;

    localparam int LAST = 19;
    localparam int DIF_HI [12] = '{2, 6, 3, 7, 1, 5, 3, 7, 4, 5, 6, 7};
    localparam int DIF_LO [12] = '{0, 4, 1, 5, 0, 4, 2, 6, 0, 1, 2, 3};
    localparam logic [3:0] SUB_OPS [4] = '{4'b0011, 4'b1101, 4'b1110, 4'b0000};

    // configuration
    q_t                z_min_reg, r_min_reg, phi_min_reg, scale_reg;
    logic [DATA_W-1:0] inv_z_reg, inv_r_reg, inv_phi_reg;
    q_t                sz_reg, sr_reg, sp_reg;

    q_t         tbl_reg [TABLE_WORDS];
    logic [LAST:0] vld_reg;
    logic       en, beat_in, query;
    logic [IDX_W-1:0] in_idx;

    // stage registers
    q_t               p0_x_reg, p0_y_reg, p0_z_reg, p0_phi_reg, p0_ctab_reg, p0_stab_reg;
    logic [DIV_DEN_W-1:0] p0_r_reg;
    q_t               p0_v_reg [24];
    q_t               p1_zd_reg, p1_rd_reg, p1_phd_reg;
    q_t               p1_v_reg [24];
    q_t               p1_dif_reg [3][12];
    logic [DIV_NUM_W-1:0] p1_numx_reg, p1_numy_reg, p1_numi_reg;
    logic [DIV_DEN_W-1:0] p1_den_reg;
    side_t            side_reg [1:13];
    q_t               p2_fz_reg, p2_fr_reg, p2_fp_reg;
    q_t               p2_v_reg [24];
    q_t               p2_dif_reg [3][12];
    q_t               p3_fz_reg, p3_fr_reg, p3_fp_reg, p3_gz_reg, p3_gr_reg, p3_gp_reg;
    q_t               p3_v_reg [24];
    q_t               p3_dif_reg [3][12];
    q_t               p4_reg [3][10];
    q_t               p4_fz_reg, p4_gz_reg, p4_fr_reg, p4_gr_reg;
    q_t               p5_reg [3][5];
    q_t               p5_fz_reg, p5_gz_reg;
    q_t               p6_reg [3][4];
    itp_t             itp_reg [8];
    logic [DIV_NUM_W-1:0] qx, qy, qi;
    q_t               p14_c_reg, p14_s_reg, p14_invr_reg;
    q_t p15_c_reg, p15_s_reg, p15_invr_reg, p15_cc_reg, p15_cs_reg, p15_ss_reg;
    q_t p15_si_reg, p15_ci_reg, p15_b0_reg, p15_b1_reg, p15_bz_reg, p15_d2_reg, p15_d5_reg;
    q_t p15_d8_reg;
    q_t p15_dr_reg [3];
    q_t p15_dp_reg [3];
    q_t p16_cc_reg, p16_cs_reg, p16_ss_reg, p16_si_reg, p16_ci_reg;
    q_t p16_cci_reg, p16_csi_reg, p16_ssi_reg;
    q_t p16_b0_reg, p16_b1_reg, p16_bz_reg, p16_d2_reg, p16_d5_reg, p16_d6_reg, p16_d7_reg;
    q_t p16_d8_reg, p16_dr1_reg, p16_dr2_reg, p16_dp1_reg, p16_dp2_reg;
    q_t p17_p_reg [4][5];
    q_t p17_b0_reg, p17_b1_reg, p17_bz_reg, p17_d2_reg, p17_d5_reg, p17_d6_reg;
    q_t p17_d7_reg, p17_d8_reg;
    q_t p18_a_reg [4];
    q_t p18_p3_reg [4];
    q_t p18_p4_reg [4];
    q_t p18_b0_reg, p18_b1_reg, p18_bz_reg, p18_d2_reg, p18_d5_reg, p18_d6_reg;
    q_t p18_d7_reg, p18_d8_reg;
    q_t out_reg [12];

    assign en       = !vld_reg[LAST] || m_tready;
    assign s_tready = en;
    assign beat_in  = s_tvalid && en;
    assign query    = beat_in && !s_tuser;
    assign in_idx   = s_tdata[OFS_INDEX +: IDX_W];
    assign m_tvalid = vld_reg[LAST];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            z_min_reg   <= '0;
            r_min_reg   <= '0;
            phi_min_reg <= '0;
            inv_z_reg   <= '0;
            inv_r_reg   <= '0;
            inv_phi_reg <= '0;
            scale_reg   <= Q_ONE;
        end else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_addr))
                REG_Z_MIN:   z_min_reg   <= cfg_wdata;
                REG_R_MIN:   r_min_reg   <= cfg_wdata;
                REG_PHI_MIN: phi_min_reg <= cfg_wdata;
                REG_INV_Z:   inv_z_reg   <= cfg_wdata;
                REG_INV_R:   inv_r_reg   <= cfg_wdata;
                REG_INV_PHI: inv_phi_reg <= cfg_wdata;
                REG_SCALE:   scale_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // scaled inverse widths follow the static configuration
    always_ff @(posedge aclk) begin
        sz_reg <= mi(scale_reg, inv_z_reg);
        sr_reg <= mi(scale_reg, inv_r_reg);
        sp_reg <= mi(scale_reg, inv_phi_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[LAST-1:0], query};
        end
    end

    always_ff @(posedge aclk) begin
        if (beat_in && s_tuser && (in_idx < IDX_W'(TABLE_WORDS))) begin
            tbl_reg[in_idx] <= s_tdata[OFS_VALUE +: DATA_W];
        end
    end

    cfi_div #(
        .NUM_W  (DIV_NUM_W),
        .DEN_W  (DIV_DEN_W),
        .STEP_W (DIV_STEP)
    ) u_div_x (
        .aclk (aclk), .en (en), .num (p1_numx_reg), .den (p1_den_reg), .quo (qx)
    );

    cfi_div #(
        .NUM_W  (DIV_NUM_W),
        .DEN_W  (DIV_DEN_W),
        .STEP_W (DIV_STEP)
    ) u_div_y (
        .aclk (aclk), .en (en), .num (p1_numy_reg), .den (p1_den_reg), .quo (qy)
    );

    cfi_div #(
        .NUM_W  (DIV_NUM_W),
        .DEN_W  (DIV_DEN_W),
        .STEP_W (DIV_STEP)
    ) u_div_i (
        .aclk (aclk), .en (en), .num (p1_numi_reg), .den (p1_den_reg), .quo (qi)
    );

    always_ff @(posedge aclk) begin
        q_t                   phw;
        logic                 rz;
        logic [DIV_DEN_W-1:0] den;
        logic [DATA_W-1:0]    magx, magy;
        q_t                   c, s;
        if (en) begin
            // capture point and table snapshot
            p0_x_reg    <= s_tdata[OFS_X +: DATA_W];
            p0_y_reg    <= s_tdata[OFS_Y +: DATA_W];
            p0_z_reg    <= s_tdata[OFS_Z +: DATA_W];
            p0_r_reg    <= s_tdata[OFS_R +: DIV_DEN_W];
            p0_phi_reg  <= s_tdata[OFS_PHI +: DATA_W];
            p0_ctab_reg <= tbl_reg[WORD_COS];
            p0_stab_reg <= tbl_reg[WORD_SIN];
            for (int k = 0; k < 24; k++) begin
                p0_v_reg[k] <= tbl_reg[k];
            end

            // offsets, corner differences, divider operands
            phw = (p0_phi_reg < phi_min_reg) ? sadd(p0_phi_reg, Q_TWO_PI) : p0_phi_reg;
            p1_phd_reg <= ssub(phw, phi_min_reg);
            p1_zd_reg  <= ssub(p0_z_reg, z_min_reg);
            p1_rd_reg  <= ssub(q_t'({1'b0, p0_r_reg}), r_min_reg);
            for (int k = 0; k < 24; k++) begin
                p1_v_reg[k] <= p0_v_reg[k];
            end
            for (int j = 0; j < 3; j++) begin
                for (int m = 0; m < 12; m++) begin
                    p1_dif_reg[j][m] <= ssub(p0_v_reg[j*8 + DIF_HI[m]], p0_v_reg[j*8 + DIF_LO[m]]);
                end
            end
            rz   = (p0_r_reg == '0);
            den  = rz ? DIV_DEN_W'(1) : p0_r_reg;
            magx = p0_x_reg[DATA_W-1] ? DATA_W'(-p0_x_reg) : DATA_W'(p0_x_reg);
            magy = p0_y_reg[DATA_W-1] ? DATA_W'(-p0_y_reg) : DATA_W'(p0_y_reg);
            p1_den_reg  <= den;
            p1_numx_reg <= (DIV_NUM_W'(magx) << FRAC_BITS) + DIV_NUM_W'(den >> 1);
            p1_numy_reg <= (DIV_NUM_W'(magy) << FRAC_BITS) + DIV_NUM_W'(den >> 1);
            p1_numi_reg <= (DIV_NUM_W'(1) << (2 * FRAC_BITS)) + DIV_NUM_W'(den >> 1);
            side_reg[1] <= '{rz: rz, negx: p0_x_reg[DATA_W-1], negy: p0_y_reg[DATA_W-1],
                             ctab: p0_ctab_reg, stab: p0_stab_reg};
            for (int k = 2; k <= 13; k++) begin
                side_reg[k] <= side_reg[k-1];
            end

            // fractions
            p2_fz_reg <= mi(p1_zd_reg, inv_z_reg);
            p2_fr_reg <= mi(p1_rd_reg, inv_r_reg);
            p2_fp_reg <= mi(p1_phd_reg, inv_phi_reg);
            p2_v_reg   <= p1_v_reg;
            p2_dif_reg <= p1_dif_reg;

            p3_fz_reg <= p2_fz_reg;
            p3_fr_reg <= p2_fr_reg;
            p3_fp_reg <= p2_fp_reg;
            p3_gz_reg <= ssub(Q_ONE, p2_fz_reg);
            p3_gr_reg <= ssub(Q_ONE, p2_fr_reg);
            p3_gp_reg <= ssub(Q_ONE, p2_fp_reg);
            p3_v_reg   <= p2_v_reg;
            p3_dif_reg <= p2_dif_reg;

            // first interpolation level
            for (int j = 0; j < 3; j++) begin
                for (int k = 0; k < 4; k++) begin
                    p4_reg[j][k] <= lerp(p3_gp_reg, p3_fp_reg, p3_v_reg[j*8 + k],
                                         p3_v_reg[j*8 + k + 4]);
                end
                for (int k = 0; k < 4; k++) begin
                    p4_reg[j][4+k] <= lerp(p3_gp_reg, p3_fp_reg, p3_dif_reg[j][2*k],
                                           p3_dif_reg[j][2*k + 1]);
                end
                for (int k = 0; k < 2; k++) begin
                    p4_reg[j][8+k] <= lerp(p3_gr_reg, p3_fr_reg, p3_dif_reg[j][8 + 2*k],
                                           p3_dif_reg[j][9 + 2*k]);
                end
            end
            p4_fz_reg <= p3_fz_reg;
            p4_gz_reg <= p3_gz_reg;
            p4_fr_reg <= p3_fr_reg;
            p4_gr_reg <= p3_gr_reg;

            // second level
            for (int j = 0; j < 3; j++) begin
                p5_reg[j][0] <= lerp(p4_gr_reg, p4_fr_reg, p4_reg[j][0], p4_reg[j][1]);
                p5_reg[j][1] <= lerp(p4_gr_reg, p4_fr_reg, p4_reg[j][2], p4_reg[j][3]);
                p5_reg[j][2] <= lerp(p4_gr_reg, p4_fr_reg, p4_reg[j][4], p4_reg[j][5]);
                p5_reg[j][3] <= lerp(p4_gz_reg, p4_fz_reg, p4_reg[j][6], p4_reg[j][7]);
                p5_reg[j][4] <= lerp(p4_gz_reg, p4_fz_reg, p4_reg[j][8], p4_reg[j][9]);
            end
            p5_fz_reg <= p4_fz_reg;
            p5_gz_reg <= p4_gz_reg;

            // third level and derivative scaling
            for (int j = 0; j < 3; j++) begin
                p6_reg[j][0] <= lerp(p5_gz_reg, p5_fz_reg, p5_reg[j][0], p5_reg[j][1]);
                p6_reg[j][1] <= mq(sz_reg, p5_reg[j][2]);
                p6_reg[j][2] <= mq(sr_reg, p5_reg[j][3]);
                p6_reg[j][3] <= mq(sp_reg, p5_reg[j][4]);
            end

            for (int j = 0; j < 3; j++) begin
                itp_reg[0].bc[j] <= mq(scale_reg, p6_reg[j][0]);
                itp_reg[0].dz[j] <= p6_reg[j][1];
                itp_reg[0].dr[j] <= p6_reg[j][2];
                itp_reg[0].dp[j] <= p6_reg[j][3];
            end
            for (int k = 1; k < 8; k++) begin
                itp_reg[k] <= itp_reg[k-1];
            end

            // direction cosines and inverse radius
            c = from_mag(side_reg[13].negx, 66'(qx));
            s = from_mag(side_reg[13].negy, 66'(qy));
            p14_c_reg    <= side_reg[13].rz ? side_reg[13].ctab : c;
            p14_s_reg    <= side_reg[13].rz ? side_reg[13].stab : s;
            p14_invr_reg <= side_reg[13].rz ? '0 : from_mag(1'b0, 66'(qi));

            // rotation
            p15_c_reg    <= p14_c_reg;
            p15_s_reg    <= p14_s_reg;
            p15_invr_reg <= p14_invr_reg;
            p15_cc_reg   <= mq(p14_c_reg, p14_c_reg);
            p15_cs_reg   <= mq(p14_c_reg, p14_s_reg);
            p15_ss_reg   <= mq(p14_s_reg, p14_s_reg);
            p15_si_reg   <= mq(p14_s_reg, p14_invr_reg);
            p15_ci_reg   <= mq(p14_c_reg, p14_invr_reg);
            p15_b0_reg   <= ssub(mq(itp_reg[7].bc[1], p14_c_reg),
                                 mq(itp_reg[7].bc[2], p14_s_reg));
            p15_b1_reg   <= sadd(mq(itp_reg[7].bc[1], p14_s_reg),
                                 mq(itp_reg[7].bc[2], p14_c_reg));
            p15_bz_reg   <= itp_reg[7].bc[0];
            p15_d2_reg   <= ssub(mq(p14_c_reg, itp_reg[7].dz[1]),
                                 mq(p14_s_reg, itp_reg[7].dz[2]));
            p15_d5_reg   <= sadd(mq(p14_s_reg, itp_reg[7].dz[1]),
                                 mq(p14_c_reg, itp_reg[7].dz[2]));
            p15_d8_reg   <= itp_reg[7].dz[0];
            for (int j = 0; j < 3; j++) begin
                p15_dr_reg[j] <= itp_reg[7].dr[j];
                p15_dp_reg[j] <= itp_reg[7].dp[j];
            end

            p16_cc_reg  <= p15_cc_reg;
            p16_cs_reg  <= p15_cs_reg;
            p16_ss_reg  <= p15_ss_reg;
            p16_si_reg  <= p15_si_reg;
            p16_ci_reg  <= p15_ci_reg;
            p16_cci_reg <= mq(p15_cc_reg, p15_invr_reg);
            p16_csi_reg <= mq(p15_cs_reg, p15_invr_reg);
            p16_ssi_reg <= mq(p15_ss_reg, p15_invr_reg);
            p16_b0_reg  <= p15_b0_reg;
            p16_b1_reg  <= p15_b1_reg;
            p16_bz_reg  <= p15_bz_reg;
            p16_d2_reg  <= p15_d2_reg;
            p16_d5_reg  <= p15_d5_reg;
            p16_d6_reg  <= ssub(mq(p15_c_reg, p15_dr_reg[0]), mq(p15_si_reg, p15_dp_reg[0]));
            p16_d7_reg  <= sadd(mq(p15_s_reg, p15_dr_reg[0]), mq(p15_ci_reg, p15_dp_reg[0]));
            p16_d8_reg  <= p15_d8_reg;
            p16_dr1_reg <= p15_dr_reg[1];
            p16_dr2_reg <= p15_dr_reg[2];
            p16_dp1_reg <= p15_dp_reg[1];
            p16_dp2_reg <= p15_dp_reg[2];

            // transverse derivative products
            p17_p_reg[0][0] <= mq(p16_cc_reg, p16_dr1_reg);
            p17_p_reg[0][1] <= mq(p16_cs_reg, p16_dr2_reg);
            p17_p_reg[0][2] <= mq(p16_csi_reg, p16_dp1_reg);
            p17_p_reg[0][3] <= mq(p16_ssi_reg, p16_dp2_reg);
            p17_p_reg[0][4] <= mq(p16_si_reg, p16_b1_reg);
            p17_p_reg[1][0] <= mq(p16_cs_reg, p16_dr1_reg);
            p17_p_reg[1][1] <= mq(p16_ss_reg, p16_dr2_reg);
            p17_p_reg[1][2] <= mq(p16_cci_reg, p16_dp1_reg);
            p17_p_reg[1][3] <= mq(p16_csi_reg, p16_dp2_reg);
            p17_p_reg[1][4] <= mq(p16_ci_reg, p16_b1_reg);
            p17_p_reg[2][0] <= mq(p16_cs_reg, p16_dr1_reg);
            p17_p_reg[2][1] <= mq(p16_cc_reg, p16_dr2_reg);
            p17_p_reg[2][2] <= mq(p16_ssi_reg, p16_dp1_reg);
            p17_p_reg[2][3] <= mq(p16_csi_reg, p16_dp2_reg);
            p17_p_reg[2][4] <= mq(p16_si_reg, p16_b0_reg);
            p17_p_reg[3][0] <= mq(p16_ss_reg, p16_dr1_reg);
            p17_p_reg[3][1] <= mq(p16_cs_reg, p16_dr2_reg);
            p17_p_reg[3][2] <= mq(p16_csi_reg, p16_dp1_reg);
            p17_p_reg[3][3] <= mq(p16_cci_reg, p16_dp2_reg);
            p17_p_reg[3][4] <= mq(p16_ci_reg, p16_b0_reg);
            p17_b0_reg <= p16_b0_reg;
            p17_b1_reg <= p16_b1_reg;
            p17_bz_reg <= p16_bz_reg;
            p17_d2_reg <= p16_d2_reg;
            p17_d5_reg <= p16_d5_reg;
            p17_d6_reg <= p16_d6_reg;
            p17_d7_reg <= p16_d7_reg;
            p17_d8_reg <= p16_d8_reg;

            // left to right saturating sums, two steps per stage
            for (int k = 0; k < 4; k++) begin
                p18_a_reg[k]  <= addsub(addsub(p17_p_reg[k][0], p17_p_reg[k][1], SUB_OPS[k][0]),
                                        p17_p_reg[k][2], SUB_OPS[k][1]);
                p18_p3_reg[k] <= p17_p_reg[k][3];
                p18_p4_reg[k] <= p17_p_reg[k][4];
            end
            p18_b0_reg <= p17_b0_reg;
            p18_b1_reg <= p17_b1_reg;
            p18_bz_reg <= p17_bz_reg;
            p18_d2_reg <= p17_d2_reg;
            p18_d5_reg <= p17_d5_reg;
            p18_d6_reg <= p17_d6_reg;
            p18_d7_reg <= p17_d7_reg;
            p18_d8_reg <= p17_d8_reg;

            out_reg[0]  <= p18_b0_reg;
            out_reg[1]  <= p18_b1_reg;
            out_reg[2]  <= p18_bz_reg;
            out_reg[3]  <= addsub(addsub(p18_a_reg[0], p18_p3_reg[0], SUB_OPS[0][2]),
                                  p18_p4_reg[0], SUB_OPS[0][3]);
            out_reg[4]  <= addsub(addsub(p18_a_reg[1], p18_p3_reg[1], SUB_OPS[1][2]),
                                  p18_p4_reg[1], SUB_OPS[1][3]);
            out_reg[5]  <= p18_d2_reg;
            out_reg[6]  <= addsub(addsub(p18_a_reg[2], p18_p3_reg[2], SUB_OPS[2][2]),
                                  p18_p4_reg[2], SUB_OPS[2][3]);
            out_reg[7]  <= addsub(addsub(p18_a_reg[3], p18_p3_reg[3], SUB_OPS[3][2]),
                                  p18_p4_reg[3], SUB_OPS[3][3]);
            out_reg[8]  <= p18_d5_reg;
            out_reg[9]  <= p18_d6_reg;
            out_reg[10] <= p18_d7_reg;
            out_reg[11] <= p18_d8_reg;
        end
    end

    for (genvar g = 0; g < 12; g++) begin : g_out
        assign m_tdata[g*DATA_W +: DATA_W] = out_reg[g];
    end

endmodule

>>> src/cfi_div.sv
// cfi_div: pipelined unsigned restoring divider, STEP_W quotient bits per stage
// depends on nothing; stalls with the enable of the surrounding pipeline
module cfi_div #(
    parameter int NUM_W  = 48,
    parameter int DEN_W  = 31,
    parameter int STEP_W = 4
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [NUM_W-1:0] quo
);

    localparam int STAGES = NUM_W / STEP_W;

    logic [DEN_W-1:0] rem_reg  [STAGES];
    logic [NUM_W-1:0] num_reg  [STAGES];
    logic [NUM_W-1:0] quo_reg  [STAGES];
    logic [DEN_W-1:0] den_reg  [STAGES];
    logic [DEN_W-1:0] rem_next [STAGES];
    logic [NUM_W-1:0] num_next [STAGES];
    logic [NUM_W-1:0] quo_next [STAGES];
    logic [DEN_W-1:0] den_next [STAGES];

    always_comb begin
        logic [DEN_W:0]   t;
        logic [DEN_W-1:0] r;
        logic [NUM_W-1:0] n;
        logic [NUM_W-1:0] q;
        logic [DEN_W-1:0] d;
        for (int k = 0; k < STAGES; k++) begin
            if (k == 0) begin
                r = '0;
                n = num;
                q = '0;
                d = den;
            end else begin
                r = rem_reg[k-1];
                n = num_reg[k-1];
                q = quo_reg[k-1];
                d = den_reg[k-1];
            end
            for (int b = 0; b < STEP_W; b++) begin
                t = {r, n[NUM_W-1]};
                n = {n[NUM_W-2:0], 1'b0};
                if (t >= {1'b0, d}) begin
                    t = t - {1'b0, d};
                    q = {q[NUM_W-2:0], 1'b1};
                end else begin
                    q = {q[NUM_W-2:0], 1'b0};
                end
                r = t[DEN_W-1:0];
            end
            rem_next[k] = r;
            num_next[k] = n;
            quo_next[k] = q;
            den_next[k] = d;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < STAGES; k++) begin
                rem_reg[k] <= rem_next[k];
                num_reg[k] <= num_next[k];
                quo_reg[k] <= quo_next[k];
                den_reg[k] <= den_next[k];
            end
        end
    end

    assign quo = quo_reg[STAGES-1];

endmodule

>>> tb/cylindrical_field_interpolator_tb.sv
// cylindrical_field_interpolator_tb: self-checking testbench for the cylindrical field interpolator
// holds its own saturating Q16.16 model of the block; depends on cfi_pkg and the rtl in src
module cylindrical_field_interpolator_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import cfi_pkg::*;

    localparam longint QMAX = 64'sd2147483647;
    localparam longint QMIN = -64'sd2147483648;
    localparam longint TWO_PI_Q = (64'h6487ED511 + 64'h8000) >> 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RAND_ITEMS = 450;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic                  s_tuser = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [DATA_W-1:0]     cfg_wdata = '0;

    cylindrical_field_interpolator dut (.*);

    always #5 aclk = ~aclk;

    typedef struct {
        logic        act;
        logic [4:0]  idx;
        logic [31:0] val;
        logic [31:0] x, y, z;
        logic [30:0] r;
        logic [31:0] phi;
        logic        typed;
    } beat_t;

    // shadow state of the block
    logic signed [31:0] corner_words [TABLE_WORDS];
    logic [31:0]        cfg_shadow [7];
    logic [M_TDATA_W-1:0] field_q [$];

    int errors = 0;
    int n_query = 0;
    int n_load = 0;
    int n_checked = 0;
    int cyc = 0;
    int hold_left = 0;
    int ready_mode = 0;

    function automatic longint q_sat(longint v);
        if (v > QMAX) return QMAX;
        if (v < QMIN) return QMIN;
        return v;
    endfunction

    function automatic longint q_add(longint a, longint b);
        return q_sat(a + b);
    endfunction

    function automatic longint q_sub(longint a, longint b);
        return q_sat(a - b);
    endfunction

    function automatic longint q_mul(longint a, longint b, int sh);
        logic [63:0]  ua, ub;
        logic [127:0] p;
        logic         neg;
        neg = (a < 0) != (b < 0);
        ua = a < 0 ? -a : a;
        ub = b < 0 ? -b : b;
        p = 128'(ua) * 128'(ub);
        p = (p + (128'd1 << (sh - 1))) >> sh;
        if (p >= 128'h8000_0000) return neg ? QMIN : QMAX;
        return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
    endfunction

    function automatic longint mq(longint a, longint b);
        return q_mul(a, b, FRAC_BITS);
    endfunction

    function automatic longint blend(longint g, longint f, longint a, longint b);
        return q_add(mq(g, a), mq(f, b));
    endfunction

    function automatic longint q_div(longint num, longint den);
        logic [63:0] m, q;
        m = (num < 0 ? -num : num) << FRAC_BITS;
        q = (m + den / 2) / den;
        if (q >= 64'h8000_0000) return num < 0 ? QMIN : QMAX;
        return num < 0 ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint sreg(int i);
        return longint'($signed(cfg_shadow[i]));
    endfunction

    function automatic logic [M_TDATA_W-1:0] field_at(longint x, longint y, longint z,
                                                      longint r, longint phi);
        longint fz, gz, fr, gr, fp, gp, sz, sr, sp, c, s, invr, b0, b1, acc, t0, t1;
        longint cc, cs, ss, cci, csi, ssi, si, ci, iz, ir, ip, scale, p_min;
        longint v[8];
        longint bc[3], dz[3], dr[3], dp[3], d[9], o[12];
        logic [M_TDATA_W-1:0] res;
        iz = cfg_shadow[REG_INV_Z];
        ir = cfg_shadow[REG_INV_R];
        ip = cfg_shadow[REG_INV_PHI];
        scale = sreg(REG_SCALE);
        p_min = sreg(REG_PHI_MIN);
        if (phi < p_min) phi = q_add(phi, TWO_PI_Q);
        fz = q_mul(q_sub(z, sreg(REG_Z_MIN)), iz, 32); gz = q_sub(65536, fz);
        fr = q_mul(q_sub(r, sreg(REG_R_MIN)), ir, 32); gr = q_sub(65536, fr);
        fp = q_mul(q_sub(phi, p_min), ip, 32); gp = q_sub(65536, fp);
        sz = q_mul(scale, iz, 32); sr = q_mul(scale, ir, 32); sp = q_mul(scale, ip, 32);
        for (int j = 0; j < 3; j++) begin
            for (int k = 0; k < 8; k++) v[k] = corner_words[j*8+k];
            t0 = blend(gr, fr, blend(gp, fp, v[0], v[4]), blend(gp, fp, v[1], v[5]));
            t1 = blend(gr, fr, blend(gp, fp, v[2], v[6]), blend(gp, fp, v[3], v[7]));
            bc[j] = mq(scale, blend(gz, fz, t0, t1));
            t0 = blend(gp, fp, q_sub(v[2], v[0]), q_sub(v[6], v[4]));
            t1 = blend(gp, fp, q_sub(v[3], v[1]), q_sub(v[7], v[5]));
            dz[j] = mq(sz, blend(gr, fr, t0, t1));
            t0 = blend(gp, fp, q_sub(v[1], v[0]), q_sub(v[5], v[4]));
            t1 = blend(gp, fp, q_sub(v[3], v[2]), q_sub(v[7], v[6]));
            dr[j] = mq(sr, blend(gz, fz, t0, t1));
            t0 = blend(gr, fr, q_sub(v[4], v[0]), q_sub(v[5], v[1]));
            t1 = blend(gr, fr, q_sub(v[6], v[2]), q_sub(v[7], v[3]));
            dp[j] = mq(sp, blend(gz, fz, t0, t1));
        end
        if (r > 0) begin
            invr = q_sat(((64'd1 << (2 * FRAC_BITS)) + r / 2) / r);
            c = q_div(x, r);
            s = q_div(y, r);
        end else begin
            invr = 0;
            c = corner_words[WORD_COS];
            s = corner_words[WORD_SIN];
        end
        b0 = q_sub(mq(bc[1], c), mq(bc[2], s));
        b1 = q_add(mq(bc[1], s), mq(bc[2], c));
        cc = mq(c, c); cs = mq(c, s); ss = mq(s, s);
        cci = mq(cc, invr); csi = mq(cs, invr); ssi = mq(ss, invr);
        si = mq(s, invr); ci = mq(c, invr);
        acc = q_sub(mq(cc, dr[1]), mq(cs, dr[2]));
        acc = q_sub(acc, mq(csi, dp[1])); acc = q_add(acc, mq(ssi, dp[2]));
        d[0] = q_add(acc, mq(si, b1));
        acc = q_sub(mq(cs, dr[1]), mq(ss, dr[2]));
        acc = q_add(acc, mq(cci, dp[1])); acc = q_sub(acc, mq(csi, dp[2]));
        d[1] = q_sub(acc, mq(ci, b1));
        d[2] = q_sub(mq(c, dz[1]), mq(s, dz[2]));
        acc = q_add(mq(cs, dr[1]), mq(cc, dr[2]));
        acc = q_sub(acc, mq(ssi, dp[1])); acc = q_sub(acc, mq(csi, dp[2]));
        d[3] = q_sub(acc, mq(si, b0));
        acc = q_add(mq(ss, dr[1]), mq(cs, dr[2]));
        acc = q_add(acc, mq(csi, dp[1])); acc = q_add(acc, mq(cci, dp[2]));
        d[4] = q_add(acc, mq(ci, b0));
        d[5] = q_add(mq(s, dz[1]), mq(c, dz[2]));
        d[6] = q_sub(mq(c, dr[0]), mq(si, dp[0]));
        d[7] = q_add(mq(s, dr[0]), mq(ci, dp[0]));
        d[8] = dz[0];
        o[0] = b0; o[1] = b1; o[2] = bc[0];
        for (int k = 0; k < 9; k++) o[3+k] = d[k];
        for (int k = 0; k < 12; k++) res[k*32 +: 32] = o[k][31:0];
        return res;
    endfunction

    // one beat on the input channel; returns right after the edge that takes it
    task automatic send_beat(beat_t b);
        s_tvalid <= 1'b1;
        s_tuser  <= b.act;
        s_tdata  <= {4'b0, b.phi, b.r, b.z, b.y, b.x, b.val, b.idx};
        do @(posedge aclk); while (!s_tready);
        if (b.act) begin
            n_load++;
            if (b.idx < TABLE_WORDS) corner_words[b.idx] = b.val;
        end else begin
            n_query++;
            if (b.typed) field_q.push_back('0);
            else field_q.push_back(field_at(longint'($signed(b.x)), longint'($signed(b.y)),
                                            longint'($signed(b.z)), longint'(b.r),
                                            longint'($signed(b.phi))));
        end
    endtask

    int burst_left = 0;

    task automatic send_paced(beat_t b);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 40);
        end
        send_beat(b);
        burst_left--;
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (field_q.size() != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
    endtask

    // the caller drops the write enable after its last write
    task automatic write_cfg(cfg_reg_t a, logic [31:0] v);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= a;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_shadow[a] = v;
    endtask

    function automatic logic [31:0] pick_q(int small_bits);
        if ($urandom_range(0, 3) == 0) return $urandom();
        return 32'($signed($urandom_range(0, (1 << small_bits) - 1)) - (1 << (small_bits - 1)));
    endfunction

    function automatic beat_t rand_beat(int load_pct);
        beat_t b;
        b.typed = 1'b0;
        b.act = $urandom_range(0, 99) < load_pct;
        b.idx = $urandom_range(0, 7) == 0 ? 5'($urandom()) : 5'($urandom_range(0, 25));
        b.val = pick_q(19);
        b.x = pick_q(19);
        b.y = pick_q(19);
        b.z = pick_q(19);
        case ($urandom_range(0, 9))
            0:       b.r = '0;
            1, 2:    b.r = 31'($urandom());
            default: b.r = 31'($urandom_range(0, 32'h4_0000));
        endcase
        b.phi = pick_q(19);
        return b;
    endfunction

    task automatic fill_words(logic zero);
        beat_t b;
        b = rand_beat(100);
        for (int i = 0; i < TABLE_WORDS; i++) begin
            b.act = 1'b1;
            b.idx = 5'(i);
            b.val = zero ? 32'h0 : pick_q(19);
            send_paced(b);
        end
    endtask

    beat_t directed [$];

    function automatic beat_t row(logic act, logic [4:0] idx, logic [31:0] val, logic [31:0] x,
                                  logic [31:0] y, logic [31:0] z, logic [30:0] r,
                                  logic [31:0] phi, logic typed);
        beat_t b;
        b = '{act, idx, val, x, y, z, r, phi, typed};
        return b;
    endfunction

    always @(posedge aclk) begin
        cyc++;
        if (cyc > CYCLE_LIMIT) begin
            $display("cylindrical_field_interpolator regression: fail");
            $finish;
        end
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else begin
            if (cyc % 97 == 0) ready_mode = $urandom_range(0, 2);
            case (ready_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= $urandom_range(0, 3) != 0;
                default: m_tready <= $urandom_range(0, 3) == 0;
            endcase
        end
    end

    string field_names [12] = '{"b_x", "b_y", "b_z", "dbx_dx", "dbx_dy", "dbx_dz",
                                "dby_dx", "dby_dy", "dby_dz", "dbz_dx", "dbz_dy", "dbz_dz"};

    always @(posedge aclk) begin
        logic [M_TDATA_W-1:0] want;
        if (aresetn && m_tvalid && m_tready) begin
            if (field_q.size() == 0) begin
                $error("result beat with nothing expected: %h", m_tdata);
                errors++;
            end else begin
                want = field_q.pop_front();
                n_checked++;
                for (int k = 0; k < 12; k++) begin
                    if (m_tdata[k*32 +: 32] !== want[k*32 +: 32]) begin
                        $error("%s expected %h got %h", field_names[k],
                               want[k*32 +: 32], m_tdata[k*32 +: 32]);
                        errors++;
                    end
                end
            end
        end
    end

    initial begin
        beat_t b;
        for (int i = 0; i < 7; i++) cfg_shadow[i] = 32'h0;
        cfg_shadow[REG_SCALE] = 32'h0001_0000;
        for (int i = 0; i < TABLE_WORDS; i++) corner_words[i] = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part on reset settings; a zero table gives an all-zero result
        fill_words(1'b1);
        directed.push_back(row(0, 0, 0, 0, 0, 0, 0, 0, 1));
        directed.push_back(row(0, 0, 0, 32'h0001_0000, 32'hFFFF_0000, 0, 0, 32'h8000_0000, 1));
        directed.push_back(row(0, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                               31'h7FFF_FFFF, 32'h7FFF_FFFF, 1));
        directed.push_back(row(0, 0, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1,
                               32'hFFFF_FFFF, 1));
        directed.push_back(row(1, 26, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0));
        directed.push_back(row(1, 31, 32'h7FFF_FFFF, 0, 0, 0, 0, 0, 0));
        directed.push_back(row(0, 0, 0, 0, 0, 0, 0, 0, 1));
        directed.push_back(row(1, 0, 32'h7FFF_FFFF, 0, 0, 0, 0, 0, 0));
        directed.push_back(row(1, 7, 32'h8000_0000, 0, 0, 0, 0, 0, 0));
        directed.push_back(row(1, 8, 32'h0002_0000, 0, 0, 0, 0, 0, 0));
        directed.push_back(row(1, 16, 32'hFFFC_8000, 0, 0, 0, 0, 0, 0));
        directed.push_back(row(1, 24, 32'h0001_0000, 0, 0, 0, 0, 0, 0));
        directed.push_back(row(1, 25, 32'h0000_8000, 0, 0, 0, 0, 0, 0));
        directed.push_back(row(0, 0, 0, 0, 0, 0, 0, 0, 0));
        directed.push_back(row(0, 0, 0, 32'h0001_0000, 32'h0001_0000, 0, 31'h1_0000, 0, 0));
        directed.push_back(row(0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1,
                               32'h7FFF_FFFF, 0));
        directed.push_back(row(0, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                               31'h7FFF_FFFF, 32'h8000_0000, 0));
        directed.push_back(row(0, 0, 0, 32'hFFFF_0000, 32'h0, 32'h0, 31'h1_0000,
                               32'hFFFF_FFFF, 0));
        foreach (directed[i]) send_paced(directed[i]);
        wait_idle();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    write_cfg(REG_Z_MIN, 32'hFFFF_0000);
                    write_cfg(REG_R_MIN, 32'h0001_0000);
                    write_cfg(REG_PHI_MIN, 32'hFFFF_8000);
                    write_cfg(REG_INV_Z, 32'h8000_0000);
                    write_cfg(REG_INV_R, 32'h8000_0000);
                    write_cfg(REG_INV_PHI, 32'hA2F9_836E);
                    write_cfg(REG_SCALE, 32'h0001_0000);
                end
                1: begin
                    write_cfg(REG_Z_MIN, 32'h7FFF_FFFF);
                    write_cfg(REG_R_MIN, 32'h8000_0000);
                    write_cfg(REG_PHI_MIN, 32'h7FFF_FFFF);
                    write_cfg(REG_INV_Z, 32'hFFFF_FFFF);
                    write_cfg(REG_INV_R, 32'hFFFF_FFFF);
                    write_cfg(REG_INV_PHI, 32'hFFFF_FFFF);
                    write_cfg(REG_SCALE, 32'h8000_0000);
                end
                2: begin
                    write_cfg(REG_Z_MIN, 32'h8000_0000);
                    write_cfg(REG_R_MIN, 32'h7FFF_FFFF);
                    write_cfg(REG_PHI_MIN, 32'h8000_0000);
                    write_cfg(REG_INV_Z, 32'h0);
                    write_cfg(REG_INV_R, 32'h0000_0001);
                    write_cfg(REG_INV_PHI, 32'h0);
                    write_cfg(REG_SCALE, 32'h7FFF_FFFF);
                end
                default: begin
                    write_cfg(REG_Z_MIN, pick_q(19));
                    write_cfg(REG_R_MIN, 32'($urandom_range(0, 32'h2_0000)));
                    write_cfg(REG_PHI_MIN, pick_q(19));
                    write_cfg(REG_INV_Z, $urandom());
                    write_cfg(REG_INV_R, $urandom());
                    write_cfg(REG_INV_PHI, $urandom());
                    write_cfg(REG_SCALE, pick_q(18));
                end
            endcase
            cfg_wr_en <= 1'b0;
            fill_words(1'b0);
            if (phase == 1) hold_left = 400;
            for (int i = 0; i < RAND_ITEMS; i++) begin
                b = rand_beat(25);
                send_paced(b);
            end
            wait_idle();
        end

        $display("covered %0d queries and %0d table loads over five register settings",
                 n_query, n_load);
        $display("%0d result beats checked, %0d mismatches", n_checked, errors);
        if (errors == 0) begin
            $display("cylindrical_field_interpolator regression: pass");
        end else begin
            $display("cylindrical_field_interpolator regression: fail");
        end
        $finish;
    end

endmodule

>>> filelist.f
src/cfi_pkg.sv
src/cfi_div.sv
src/cylindrical_field_interpolator.sv
tb/cylindrical_field_interpolator_tb.sv
